[sv/gpio_irq_pkg.sv]
// ----------------------------------------------------------------------------
// GPIO bank with interrupt queue - shared definitions
// Access codes, pin modes, trigger codes, status codes, register map and
// default sizes for the pin bank.
// ----------------------------------------------------------------------------
package gpio_irq_pkg;

    // Default sizes
    localparam int PIN_COUNT_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths
    localparam int PIN_W    = 6;
    localparam int OP_W     = 3;
    localparam int VAL_W    = 16;
    localparam int MODE_W   = 2;
    localparam int LVL_W    = 8;
    localparam int ST_W     = 3;
    localparam int TRIG_W   = 3;
    localparam int QCNT_W   = 5;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IW   = 3;

    // Access codes
    localparam logic [OP_W-1:0] OP_SET_MODE = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE    = 3'd1;
    localparam logic [OP_W-1:0] OP_READ     = 3'd2;
    localparam logic [OP_W-1:0] OP_ANALOG   = 3'd3;
    localparam logic [OP_W-1:0] OP_TOGGLE   = 3'd4;
    localparam logic [OP_W-1:0] OP_POP      = 3'd5;

    // Pin modes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INPUT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUTPUT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PULLUP = 2'd3;

    // Interrupt trigger codes
    localparam logic [TRIG_W-1:0] TRIG_NONE    = 3'd0;
    localparam logic [TRIG_W-1:0] TRIG_LOW     = 3'd1;
    localparam logic [TRIG_W-1:0] TRIG_CHANGE  = 3'd2;
    localparam logic [TRIG_W-1:0] TRIG_RISING  = 3'd3;
    localparam logic [TRIG_W-1:0] TRIG_FALLING = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_PIN    = 3'd1;
    localparam logic [ST_W-1:0] ST_WRONG_MODE = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_VALUE  = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY      = 3'd4;

    // Register map (word index)
    localparam logic [REG_IW-1:0] REG_LOWEST  = 3'd0;
    localparam logic [REG_IW-1:0] REG_HIGHEST = 3'd1;
    localparam logic [REG_IW-1:0] REG_IRQ0PIN = 3'd2;
    localparam logic [REG_IW-1:0] REG_IRQ1PIN = 3'd3;
    localparam logic [REG_IW-1:0] REG_IRQ0MD  = 3'd4;
    localparam logic [REG_IW-1:0] REG_IRQ1MD  = 3'd5;

    // Register reset values
    localparam logic [PIN_W-1:0]  RST_LOWEST  = 6'd0;
    localparam logic [PIN_W-1:0]  RST_HIGHEST = 6'd10;
    localparam logic [PIN_W-1:0]  RST_IRQ0PIN = 6'd2;
    localparam logic [PIN_W-1:0]  RST_IRQ1PIN = 6'd3;

    // Stored pin state: mode and level
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LVL_W-1:0]  level;
    } t_pin_state;

endpackage

[sv/gpio_pins_with_irq_queue.sv]
// An access is registered in stage 1 and answered from the result register;
// o_done is high for one cycle per access.
// Throughput: one access per cycle, set by the single read-modify-write of
// the pin memory; busy stays low and the receiver cannot stall.
// Reset (synchronous, active low) clears registers, pin valid bits and queue.
// ----------------------------------------------------------------------------
// GPIO pin bank with edge/level interrupt queue
// Stage 1 registers the access and the pin state read from memory (bypassed
// from the write of the access before). Stage 2 decides the access, writes
// pin state back, pushes or pops the interrupt queue and registers the word.
// ----------------------------------------------------------------------------
module gpio_pins_with_irq_queue #(
    parameter int PIN_COUNT   = gpio_irq_pkg::PIN_COUNT_DEF,
    parameter int QUEUE_DEPTH = gpio_irq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // access channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic [gpio_irq_pkg::OP_W-1:0]         i_op,
    input  logic [gpio_irq_pkg::PIN_W-1:0]        i_pin_index,
    input  logic signed [gpio_irq_pkg::VAL_W-1:0] i_write_value,
    input  logic [gpio_irq_pkg::MODE_W-1:0]       i_new_mode,
    // result channel
    output logic                                  o_done,
    output logic [gpio_irq_pkg::LVL_W-1:0]        o_read_value,
    output logic [gpio_irq_pkg::ST_W-1:0]         o_status,
    output logic [gpio_irq_pkg::PIN_W-1:0]        o_irq_pin_out,
    output logic                                  o_irq_valid,
    output logic                                  o_queue_full,
    output logic [gpio_irq_pkg::QCNT_W-1:0]       o_queue_count,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gpio_irq_pkg::APB_AW-1:0]       paddr,
    input  logic [gpio_irq_pkg::APB_DW-1:0]       pwdata,
    output logic [gpio_irq_pkg::APB_DW-1:0]       prdata,
    output logic                                  pready
);
    import gpio_irq_pkg::*;

    localparam int PAW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PIN_W:0]   PIN_LIMIT = (PIN_W + 1)'(PIN_COUNT);
    localparam logic [QCW-1:0]   Q_FULL    = QCW'(QUEUE_DEPTH);
    localparam logic [QAW-1:0]   Q_LAST    = QAW'(QUEUE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PIN_W-1:0]  r_lowest, r_highest, r_irq0_pin, r_irq1_pin;
    logic [TRIG_W-1:0] r_irq0_mode, r_irq1_mode;
    logic              cfg_wr;
    logic [REG_IW-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_AW-1:2];

    // Write a register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest    <= RST_LOWEST;
            r_highest   <= RST_HIGHEST;
            r_irq0_pin  <= RST_IRQ0PIN;
            r_irq1_pin  <= RST_IRQ1PIN;
            r_irq0_mode <= TRIG_NONE;
            r_irq1_mode <= TRIG_NONE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LOWEST:  r_lowest    <= pwdata[PIN_W-1:0];
                REG_HIGHEST: r_highest   <= pwdata[PIN_W-1:0];
                REG_IRQ0PIN: r_irq0_pin  <= pwdata[PIN_W-1:0];
                REG_IRQ1PIN: r_irq1_pin  <= pwdata[PIN_W-1:0];
                REG_IRQ0MD:  r_irq0_mode <= pwdata[TRIG_W-1:0];
                REG_IRQ1MD:  r_irq1_mode <= pwdata[TRIG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_LOWEST:  prdata = APB_DW'(r_lowest);
            REG_HIGHEST: prdata = APB_DW'(r_highest);
            REG_IRQ0PIN: prdata = APB_DW'(r_irq0_pin);
            REG_IRQ1PIN: prdata = APB_DW'(r_irq1_pin);
            REG_IRQ0MD:  prdata = APB_DW'(r_irq0_mode);
            REG_IRQ1MD:  prdata = APB_DW'(r_irq1_mode);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: access register and pin state read
    // ------------------------------------------------------------------
    t_pin_state                r_pin_mem [PIN_COUNT];
    logic [PIN_COUNT-1:0]      r_pin_vld;
    logic                      r_s1_vld;
    logic [OP_W-1:0]           r_op;
    logic [PIN_W-1:0]          r_pin;
    logic signed [VAL_W-1:0]   r_wval;
    logic [MODE_W-1:0]         r_nmode;
    t_pin_state                r_cur;

    // stage 2 write-back, driven below
    logic                      pin_wr;
    t_pin_state                pin_wr_data;
    logic [PAW-1:0]            rd_addr;
    logic [PAW-1:0]            wr_addr;
    logic                      rd_in_range;

    assign rd_addr     = i_pin_index[PAW-1:0];
    assign wr_addr     = r_pin[PAW-1:0];
    assign rd_in_range = {1'b0, i_pin_index} < PIN_LIMIT;

    // Track which pins hold written state; others read as reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_vld <= '0;
            r_s1_vld  <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            if (pin_wr) begin
                r_pin_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // Write back pin state, read the next pin with bypass from the write
    always_ff @(posedge i_clk) begin
        if (pin_wr) begin
            r_pin_mem[wr_addr] <= pin_wr_data;
        end
        if (pin_wr && (r_pin == i_pin_index)) begin
            r_cur <= pin_wr_data;
        end else if (rd_in_range && r_pin_vld[rd_addr]) begin
            r_cur <= r_pin_mem[rd_addr];
        end else begin
            r_cur <= '0;
        end
        r_op    <= i_op;
        r_pin   <= i_pin_index;
        r_wval  <= i_write_value;
        r_nmode <= i_new_mode;
    end

    // ------------------------------------------------------------------
    // Interrupt queue storage and pointers
    // ------------------------------------------------------------------
    logic [PIN_W-1:0] r_fifo [QUEUE_DEPTH];
    logic [PIN_W-1:0] r_fifo_rd;
    logic [QAW-1:0]   r_head, r_tail, n_head, n_tail;
    logic [QCW-1:0]   r_count, n_count;
    logic             push, pop;

    // Push at the tail, prefetch the entry at the next head
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_tail] <= r_pin;
        end
        if (push && (r_tail == n_head)) begin
            r_fifo_rd <= r_pin;
        end else begin
            r_fifo_rd <= r_fifo[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: decide the access
    // ------------------------------------------------------------------
    logic              pin_ok;
    logic              lvl_chg;
    logic              chg_bit;
    logic              changed;
    logic              hit;
    logic [TRIG_W-1:0] trig;
    logic              watched;
    logic [ST_W-1:0]   n_status;
    logic [LVL_W-1:0]  n_rdval;
    logic              n_irqv;
    logic [LVL_W-1:0]  clamp;

    assign pin_ok = ({1'b0, r_pin} < PIN_LIMIT) && (r_pin >= r_lowest)
                    && (r_pin <= r_highest);

    // Clamp an analog value to 0..255
    always_comb begin
        if (r_wval[VAL_W-1]) begin
            clamp = '0;
        end else if (r_wval[VAL_W-2:LVL_W] != '0) begin
            clamp = '1;
        end else begin
            clamp = r_wval[LVL_W-1:0];
        end
    end

    // Access decode and pin write-back
    always_comb begin
        n_status    = ST_OK;
        n_rdval     = '0;
        n_irqv      = 1'b0;
        pin_wr      = 1'b0;
        pin_wr_data = r_cur;
        lvl_chg     = 1'b0;
        chg_bit     = 1'b0;
        pop         = 1'b0;
        if (r_s1_vld) begin
            if ((r_op inside {OP_SET_MODE, OP_WRITE, OP_READ, OP_ANALOG, OP_TOGGLE})
                && !pin_ok) begin
                n_status = ST_BAD_PIN;
            end else begin
                case (r_op)
                    OP_SET_MODE: begin
                        pin_wr           = 1'b1;
                        pin_wr_data.mode = r_nmode;
                        if (r_nmode == MODE_PULLUP) begin
                            pin_wr_data.level = LVL_W'(r_cur.level == '0);
                        end
                    end
                    OP_WRITE: begin
                        if (r_cur.mode != MODE_OUTPUT) begin
                            n_status = ST_WRONG_MODE;
                        end else if (r_wval[VAL_W-1:1] != '0) begin
                            n_status = ST_BAD_VALUE;
                        end else begin
                            lvl_chg = 1'b1;
                            chg_bit = r_wval[0];
                        end
                    end
                    OP_READ: begin
                        if (r_cur.mode inside {MODE_INPUT, MODE_PULLUP}) begin
                            n_rdval = r_cur.level;
                        end else begin
                            n_status = ST_WRONG_MODE;
                        end
                    end
                    OP_ANALOG: begin
                        if (r_cur.mode != MODE_OUTPUT) begin
                            n_status = ST_WRONG_MODE;
                        end else begin
                            pin_wr            = 1'b1;
                            pin_wr_data.level = clamp;
                        end
                    end
                    OP_TOGGLE: begin
                        lvl_chg = 1'b1;
                        chg_bit = (r_cur.level == '0);
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            pop    = 1'b1;
                            n_irqv = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // Digital level change
            if (lvl_chg) begin
                pin_wr            = 1'b1;
                pin_wr_data.level = LVL_W'(chg_bit);
            end
        end
    end

    // Select the watching channel, channel zero first
    always_comb begin
        watched = 1'b1;
        trig    = TRIG_NONE;
        if (r_pin == r_irq0_pin) begin
            trig = r_irq0_mode;
        end else if (r_pin == r_irq1_pin) begin
            trig = r_irq1_mode;
        end else begin
            watched = 1'b0;
        end
    end

    assign changed = r_cur.level != LVL_W'(chg_bit);

    // Match the change against the trigger
    always_comb begin
        case (trig)
            TRIG_LOW:     hit = !chg_bit;
            TRIG_CHANGE:  hit = changed;
            TRIG_RISING:  hit = changed && chg_bit;
            TRIG_FALLING: hit = changed && !chg_bit;
            default:      hit = 1'b0;
        endcase
    end

    assign push = lvl_chg && watched && hit && (r_count != Q_FULL);

    // Advance queue pointers and count
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (pop) begin
            n_head  = (r_head == Q_LAST) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (push) begin
            n_tail  = (r_tail == Q_LAST) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                  r_done;
    logic [LVL_W-1:0]      r_read_value;
    logic [ST_W-1:0]       r_status;
    logic [PIN_W-1:0]      r_irq_pin;
    logic                  r_irq_valid;
    logic                  r_queue_full;
    logic [QCW-1:0]        r_queue_count;
    logic [QCW+QCNT_W-1:0] count_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_value  <= n_rdval;
        r_status      <= n_status;
        r_irq_pin     <= n_irqv ? r_fifo_rd : '0;
        r_irq_valid   <= n_irqv;
        r_queue_full  <= (n_count == Q_FULL);
        r_queue_count <= n_count;
    end

    assign count_ext     = {{QCNT_W{1'b0}}, r_queue_count};
    assign o_done        = r_done;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_irq_pin_out = r_irq_pin;
    assign o_irq_valid   = r_irq_valid;
    assign o_queue_full  = r_queue_full;
    assign o_queue_count = count_ext[QCNT_W-1:0];

`ifndef SYNTHESIS
    // Queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_FULL)
        else $error("interrupt queue count above depth");

    // Each rising o_done follows an accepted access via the stage 1 and result registers
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(start && !busy, 2))
        else $error("result without accepted access");

    // A popped entry always reports ok
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_irq_valid) |-> (o_status == ST_OK))
        else $error("popped entry with error status");

    // Never pop and push in one access
    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && pop))
        else $error("push and pop in one access");

    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        ((r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1)))
        else $error("queue count jumped");
`endif

endmodule

[tb/sv/tb_gpio_pins_with_irq_queue.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPIO bank with interrupt queue - self-checking testbench
// Drives pin accesses through the start/busy channel and registers through
// the APB port, predicts every result word from a local copy of pin state,
// trigger setup and interrupt queue, and checks each word field by field.
// A short directed table runs first, then random phases under varied setups.
// ----------------------------------------------------------------------------
module tb_gpio_pins_with_irq_queue;
    import gpio_irq_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int MAX_GAP      = 18;
    localparam int TAIL_CYCLES  = 6;
    localparam int PIN_MAX      = PIN_COUNT_DEF - 1;
    localparam int LVL_MAX      = 255;

    // Codes the package leaves unnamed
    localparam logic [OP_W-1:0]   OP_SPARE_LO   = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_HI   = 3'd7;
    localparam logic [TRIG_W-1:0] TRIG_RSVD_LO  = 3'd5;
    localparam logic [TRIG_W-1:0] TRIG_RSVD_MID = 3'd6;
    localparam logic [TRIG_W-1:0] TRIG_RSVD_HI  = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [LVL_W-1:0]  read_value;
        logic [ST_W-1:0]   status;
        logic [PIN_W-1:0]  irq_pin;
        logic              irq_valid;
        logic              queue_full;
        logic [QCNT_W-1:0] queue_count;
    } t_gpio_word;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [PIN_W-1:0]        pin;
        logic signed [VAL_W-1:0] value;
        logic [MODE_W-1:0]       mode;
        bit                      fixed;
        t_gpio_word              word;
    } t_access_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OP_W-1:0]         i_op;
    logic [PIN_W-1:0]        i_pin_index;
    logic signed [VAL_W-1:0] i_write_value;
    logic [MODE_W-1:0]       i_new_mode;
    logic                    o_done;
    logic [LVL_W-1:0]        o_read_value;
    logic [ST_W-1:0]         o_status;
    logic [PIN_W-1:0]        o_irq_pin_out;
    logic                    o_irq_valid;
    logic                    o_queue_full;
    logic [QCNT_W-1:0]       o_queue_count;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // Local copy of registers, pin state and interrupt queue
    logic [PIN_W-1:0]  cfg_lowest;
    logic [PIN_W-1:0]  cfg_highest;
    logic [PIN_W-1:0]  cfg_irq_pin [2];
    logic [TRIG_W-1:0] cfg_trig [2];
    logic [MODE_W-1:0] pin_mode [PIN_COUNT_DEF];
    logic [LVL_W-1:0]  pin_level [PIN_COUNT_DEF];
    logic [PIN_W-1:0]  irq_pending [$];
    t_gpio_word        words_due [$];
    t_access_row       access_table [$];

    int errors        = 0;
    int words_checked = 0;
    int accesses      = 0;
    int irq_pushes    = 0;
    int irq_drops     = 0;
    int cycle_count   = 0;
    bit quiet         = 1'b0;

    gpio_pins_with_irq_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_pin_index   (i_pin_index),
        .i_write_value (i_write_value),
        .i_new_mode    (i_new_mode),
        .o_done        (o_done),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_irq_pin_out (o_irq_pin_out),
        .o_irq_valid   (o_irq_valid),
        .o_queue_full  (o_queue_full),
        .o_queue_count (o_queue_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Give up on a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_gpio_pins_with_irq_queue: errors");
        $finish;
    end

    // Apply a digital level and test the watching channel's trigger
    function automatic void apply_level(input logic [PIN_W-1:0] p, input logic [LVL_W-1:0] nv);
        logic [TRIG_W-1:0] trig;
        bit                changed;
        bit                hit;
        changed = (nv != pin_level[p]);
        pin_level[p] = nv;
        if (p == cfg_irq_pin[0]) trig = cfg_trig[0];
        else if (p == cfg_irq_pin[1]) trig = cfg_trig[1];
        else trig = TRIG_NONE;
        case (trig)
            TRIG_LOW:     hit = (nv == '0);
            TRIG_CHANGE:  hit = changed;
            TRIG_RISING:  hit = changed && (nv == 8'd1);
            TRIG_FALLING: hit = changed && (nv == '0);
            default:      hit = 1'b0;
        endcase
        if (hit) begin
            // drop the entry when the queue is full
            if (irq_pending.size() < QUEUE_DEPTH_DEF) begin
                irq_pending.push_back(p);
                irq_pushes++;
            end else begin
                irq_drops++;
            end
        end
    endfunction

    // Predict the result word of one access and advance the local state
    function automatic t_gpio_word predict_gpio_word(input t_access_row a);
        t_gpio_word w;
        w = '0;
        if (a.op <= OP_TOGGLE && !(a.pin >= cfg_lowest && a.pin <= cfg_highest)) begin
            w.status = ST_BAD_PIN;
        end else begin
            case (a.op)
                OP_SET_MODE: begin
                    pin_mode[a.pin] = a.mode;
                    if (a.mode == MODE_PULLUP)
                        pin_level[a.pin] = (pin_level[a.pin] == '0) ? 8'd1 : 8'd0;
                end
                OP_WRITE: begin
                    if (pin_mode[a.pin] != MODE_OUTPUT) w.status = ST_WRONG_MODE;
                    else if (a.value != 0 && a.value != 1) w.status = ST_BAD_VALUE;
                    else apply_level(a.pin, a.value[LVL_W-1:0]);
                end
                OP_READ: begin
                    if (pin_mode[a.pin] != MODE_INPUT && pin_mode[a.pin] != MODE_PULLUP)
                        w.status = ST_WRONG_MODE;
                    else
                        w.read_value = pin_level[a.pin];
                end
                OP_ANALOG: begin
                    if (pin_mode[a.pin] != MODE_OUTPUT) w.status = ST_WRONG_MODE;
                    else if (a.value < 0) pin_level[a.pin] = '0;
                    else if (a.value > LVL_MAX) pin_level[a.pin] = LVL_W'(LVL_MAX);
                    else pin_level[a.pin] = a.value[LVL_W-1:0];
                end
                OP_TOGGLE: begin
                    apply_level(a.pin, (pin_level[a.pin] == '0) ? 8'd1 : 8'd0);
                end
                OP_POP: begin
                    if (irq_pending.size() == 0) begin
                        w.status = ST_EMPTY;
                    end else begin
                        w.irq_pin   = irq_pending.pop_front();
                        w.irq_valid = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        w.queue_full  = (irq_pending.size() >= QUEUE_DEPTH_DEF);
        w.queue_count = QCNT_W'(irq_pending.size());
        return w;
    endfunction

    // Draw one random access, mostly aimed at watched and valid pins
    function automatic t_access_row random_access(input int pop_pct);
        t_access_row r;
        int          pick;
        r.fixed = 1'b0;
        r.word  = '0;
        pick = $urandom_range(0, 99);
        if (pick < pop_pct) begin
            r.op = OP_POP;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 14) r.op = OP_SET_MODE;
            else if (pick < 44) r.op = OP_WRITE;
            else if (pick < 56) r.op = OP_READ;
            else if (pick < 66) r.op = OP_ANALOG;
            else if (pick < 97) r.op = OP_TOGGLE;
            else r.op = (pick % 2 == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) r.pin = cfg_irq_pin[pick % 2];
        else if (pick < 85 && cfg_lowest <= cfg_highest)
            r.pin = PIN_W'($urandom_range(cfg_highest, cfg_lowest));
        else r.pin = PIN_W'($urandom_range(0, PIN_MAX));
        case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: r.value = VAL_W'($urandom_range(0, 1));
            5:             r.value = VAL_W'($urandom());
            6:             r.value = VAL_W'($urandom_range(0, 300));
            default: begin
                case ($urandom_range(0, 3))
                    0:       r.value = VAL_MIN;
                    1:       r.value = VAL_MAX;
                    2:       r.value = -16'sd1;
                    default: r.value = 16'sd256;
                endcase
            end
        endcase
        r.mode = ($urandom_range(0, 4) == 4) ? MODE_OUTPUT : MODE_W'($urandom_range(0, 3));
        return r;
    endfunction

    // Read a register back and compare
    task automatic check_register(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("register %0d: expected %0h, actual %0h", idx, want, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register, mirror it locally, read it back
    task automatic set_register(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_LOWEST:  cfg_lowest     = data[PIN_W-1:0];
            REG_HIGHEST: cfg_highest    = data[PIN_W-1:0];
            REG_IRQ0PIN: cfg_irq_pin[0] = data[PIN_W-1:0];
            REG_IRQ1PIN: cfg_irq_pin[1] = data[PIN_W-1:0];
            REG_IRQ0MD:  cfg_trig[0]    = data[TRIG_W-1:0];
            REG_IRQ1MD:  cfg_trig[1]    = data[TRIG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_register(idx, data);
    endtask

    task automatic configure(input logic [PIN_W-1:0] lo, input logic [PIN_W-1:0] hi,
                             input logic [PIN_W-1:0] p0, input logic [PIN_W-1:0] p1,
                             input logic [TRIG_W-1:0] m0, input logic [TRIG_W-1:0] m1);
        set_register(REG_LOWEST, APB_DW'(lo));
        set_register(REG_HIGHEST, APB_DW'(hi));
        set_register(REG_IRQ0PIN, APB_DW'(p0));
        set_register(REG_IRQ1PIN, APB_DW'(p1));
        set_register(REG_IRQ0MD, APB_DW'(m0));
        set_register(REG_IRQ1MD, APB_DW'(m1));
    endtask

    // Hold off, present one access, wait for it to be taken, log its word
    task automatic issue_access(input t_access_row a);
        int         gap;
        t_gpio_word w;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_op          <= a.op;
        i_pin_index   <= a.pin;
        i_write_value <= a.value;
        i_new_mode    <= a.mode;
        do @(posedge i_clk); while (busy);
        accesses++;
        w = predict_gpio_word(a);
        words_due.push_back(a.fixed ? a.word : w);
    endtask

    // Drop start and let every outstanding word come back
    task automatic drain_words();
        @(negedge i_clk);
        start <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [PIN_W-1:0] pin,
                           input logic signed [VAL_W-1:0] value,
                           input logic [MODE_W-1:0] mode, input bit fixed,
                           input logic [ST_W-1:0] status, input logic [QCNT_W-1:0] count);
        t_access_row r;
        r.op     = op;
        r.pin    = pin;
        r.value  = value;
        r.mode   = mode;
        r.fixed  = fixed;
        r.word   = '0;
        r.word.status      = status;
        r.word.queue_count = count;
        access_table.push_back(r);
    endtask

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin : check_words
        t_gpio_word due;
        if (i_rst_n && o_done) begin
            if (words_due.size() == 0) begin
                $error("result word with none expected");
                errors++;
            end else begin
                due = words_due.pop_front();
                words_checked++;
                if (o_read_value !== due.read_value) begin
                    $error("read_value: expected %0d, actual %0d", due.read_value, o_read_value);
                    errors++;
                end
                if (o_status !== due.status) begin
                    $error("status: expected %0d, actual %0d", due.status, o_status);
                    errors++;
                end
                if (o_irq_pin_out !== due.irq_pin) begin
                    $error("irq_pin_out: expected %0d, actual %0d", due.irq_pin, o_irq_pin_out);
                    errors++;
                end
                if (o_irq_valid !== due.irq_valid) begin
                    $error("irq_valid: expected %0d, actual %0d", due.irq_valid, o_irq_valid);
                    errors++;
                end
                if (o_queue_full !== due.queue_full) begin
                    $error("queue_full: expected %0d, actual %0d", due.queue_full, o_queue_full);
                    errors++;
                end
                if (o_queue_count !== due.queue_count) begin
                    $error("queue_count: expected %0d, actual %0d",
                           due.queue_count, o_queue_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [PIN_W-1:0]  lo;
        logic [PIN_W-1:0]  hi;
        logic [PIN_W-1:0]  p0;
        logic [PIN_W-1:0]  p1;
        logic [TRIG_W-1:0] m0;
        logic [TRIG_W-1:0] m1;
        int                pop_pct;
        int                n_items;

        // Hold every input at a known value through reset
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = OP_SET_MODE;
        i_pin_index   = '0;
        i_write_value = '0;
        i_new_mode    = MODE_IDLE;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        cfg_lowest     = RST_LOWEST;
        cfg_highest    = RST_HIGHEST;
        cfg_irq_pin[0] = RST_IRQ0PIN;
        cfg_irq_pin[1] = RST_IRQ1PIN;
        cfg_trig[0]    = TRIG_NONE;
        cfg_trig[1]    = TRIG_NONE;
        for (int p = 0; p < PIN_COUNT_DEF; p++) begin
            pin_mode[p]  = MODE_IDLE;
            pin_level[p] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers come out of reset at their defaults
        check_register(REG_LOWEST, APB_DW'(RST_LOWEST));
        check_register(REG_HIGHEST, APB_DW'(RST_HIGHEST));
        check_register(REG_IRQ0PIN, APB_DW'(RST_IRQ0PIN));
        check_register(REG_IRQ1PIN, APB_DW'(RST_IRQ1PIN));
        check_register(REG_IRQ0MD, APB_DW'(TRIG_NONE));
        check_register(REG_IRQ1MD, APB_DW'(TRIG_NONE));

        // Directed table: channel zero on change, channel one on falling
        configure(RST_LOWEST, RST_HIGHEST, RST_IRQ0PIN, RST_IRQ1PIN, TRIG_CHANGE, TRIG_FALLING);
        add_row(OP_POP,      0,       0,       MODE_IDLE,   1, ST_EMPTY,      0);
        add_row(OP_WRITE,    PIN_MAX, 1,       MODE_IDLE,   1, ST_BAD_PIN,    0);
        add_row(OP_READ,     5,       0,       MODE_IDLE,   1, ST_WRONG_MODE, 0);
        add_row(OP_ANALOG,   5,       100,     MODE_IDLE,   1, ST_WRONG_MODE, 0);
        add_row(OP_SET_MODE, 2,       0,       MODE_OUTPUT, 1, ST_OK,         0);
        add_row(OP_WRITE,    2,       2,       MODE_IDLE,   1, ST_BAD_VALUE,  0);
        add_row(OP_WRITE,    2,       -1,      MODE_IDLE,   1, ST_BAD_VALUE,  0);
        add_row(OP_WRITE,    2,       1,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_WRITE,    2,       1,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_WRITE,    2,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_ANALOG,   2,       VAL_MAX, MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_ANALOG,   2,       VAL_MIN, MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_ANALOG,   2,       300,     MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_SET_MODE, 2,       0,       MODE_PULLUP, 0, ST_OK,         0);
        add_row(OP_READ,     2,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_SET_MODE, 3,       0,       MODE_PULLUP, 0, ST_OK,         0);
        add_row(OP_READ,     3,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_TOGGLE,   3,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_TOGGLE,   3,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_TOGGLE,   PIN_MAX, 0,       MODE_IDLE,   1, ST_BAD_PIN,    3);
        add_row(OP_SET_MODE, 11,      0,       MODE_INPUT,  1, ST_BAD_PIN,    3);
        add_row(OP_SPARE_LO, 0,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_POP,      0,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_POP,      0,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_POP,      0,       0,       MODE_IDLE,   0, ST_OK,         0);
        add_row(OP_POP,      0,       0,       MODE_IDLE,   0, ST_OK,         0);
        foreach (access_table[i]) issue_access(access_table[i]);
        drain_words();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            n_items = PHASE_ITEMS;
            case (ph)
                0: begin
                    // whole range valid, watch the two end pins, rare pops
                    lo = '0;  hi = PIN_W'(PIN_MAX);  p0 = '0;  p1 = PIN_W'(PIN_MAX);
                    m0 = TRIG_LOW;  m1 = TRIG_CHANGE;  pop_pct = 8;
                end
                1: begin
                    // one valid pin watched by both channels
                    lo = PIN_W'(PIN_MAX);  hi = PIN_W'(PIN_MAX);
                    p0 = PIN_W'(PIN_MAX);  p1 = PIN_W'(PIN_MAX);
                    m0 = TRIG_RISING;  m1 = TRIG_FALLING;  pop_pct = 25;
                end
                2: begin
                    // empty valid range: every set-mode, write, read, analog and toggle is refused
                    lo = 6'd40;  hi = 6'd20;
                    p0 = PIN_W'($urandom_range(0, PIN_MAX));
                    p1 = PIN_W'($urandom_range(0, PIN_MAX));
                    m0 = TRIG_CHANGE;  m1 = TRIG_RSVD_MID;  pop_pct = 30;  n_items = 60;
                end
                3: begin
                    // reserved trigger codes act as none
                    lo = '0;  hi = 6'd15;  p0 = 6'd5;  p1 = 6'd6;
                    m0 = TRIG_RSVD_LO;  m1 = TRIG_RSVD_HI;  pop_pct = 30;
                end
                default: begin
                    lo = PIN_W'($urandom_range(0, 40));
                    hi = PIN_W'(lo + $urandom_range(0, 23));
                    p0 = PIN_W'($urandom_range(hi, lo));
                    p1 = ($urandom_range(0, 3) == 0) ? p0 : PIN_W'($urandom_range(hi, lo));
                    m0 = ($urandom_range(0, 5) == 0) ? TRIG_W'($urandom_range(5, 7))
                                                     : TRIG_W'($urandom_range(0, 4));
                    m1 = ($urandom_range(0, 5) == 0) ? TRIG_W'($urandom_range(5, 7))
                                                     : TRIG_W'($urandom_range(0, 4));
                    pop_pct = $urandom_range(10, 40);
                end
            endcase
            configure(lo, hi, p0, p1, m0, m1);
            for (int i = 0; i < n_items; i++) begin
                if (i % 32 == 0) quiet = $urandom_range(0, 1);
                // now and then hold the sender until the pipe is empty
                if ($urandom_range(0, 63) == 0) drain_words();
                issue_access(random_access(pop_pct));
            end
            drain_words();
        end

        $display("Ran %0d accesses over %0d register settings, %0d words checked.",
                 accesses, PHASE_COUNT + 1, words_checked);
        $display("Interrupt queue saw %0d pushes and %0d drops while full.",
                 irq_pushes, irq_drops);
        if (errors == 0) begin
            $display("tb_gpio_pins_with_irq_queue: clean");
        end else begin
            $display("tb_gpio_pins_with_irq_queue: errors");
        end
        $finish;
    end

endmodule

[sim.f]
sv/gpio_irq_pkg.sv
sv/gpio_pins_with_irq_queue.sv
tb/sv/tb_gpio_pins_with_irq_queue.sv
